[rtl/core/glcl_pkg.sv]
// Shared types and constants for the glyph cache LRU tag store.
// No dependencies; imported by every module of the block but glcl_ram.
package glcl_pkg;

  localparam int ACT_W   = 2;
  localparam int TAG_W   = 21;
  localparam int SLOT_W  = 4;
  localparam int STAMP_W = 32;

  // Action codes of an input item
  typedef enum logic [ACT_W-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Controller to datapath commands
  typedef struct packed {
    logic init;    // latch the item, reset scan accumulators
    logic issue;   // a read address is valid this cycle
    logic commit;  // apply the update and present the result
  } cmd_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_LAST   = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_t;

endpackage

[rtl/core/glyph_cache_lru_tag_store_unit.sv]
// Glyph cache LRU tag store, top level.
// Depends on glcl_pkg, glcl_ctrl, glcl_dp and glcl_ram.
//
// Fully associative tag store keyed by code point with LRU replacement by
// access stamps. An item (action, code_point) is taken at a rising edge
// where start is high and busy is low. action selects lookup, insert or
// clear; the unused code gives an all-zero result and changes nothing.
// Each item gives one result: done is high for exactly one cycle with hit,
// slot, evicted_valid and evicted_code_point valid in that cycle. The
// receiver cannot stall; fields hold until the next result.
// A lookup or insert reads one slot per cycle through the tag and stamp
// RAM read port, walking every slot before it commits; a clear or unused
// action goes straight to the commit state.
// One item is in flight at a time; busy is high until the commit cycle ends.
// Reset (synchronous, rst high) clears the valid bits and access counter;
// the RAMs need no clearing pass, since a tag or stamp is only used once
// its slot has been written.
module glyph_cache_lru_tag_store_unit #(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [glcl_pkg::ACT_W-1:0]  action,
  input  logic [glcl_pkg::TAG_W-1:0]  code_point,
  output logic                        done,
  output logic                        hit,
  output logic [glcl_pkg::SLOT_W-1:0] slot,
  output logic                        evicted_valid,
  output logic [glcl_pkg::TAG_W-1:0]  evicted_code_point
);
  import glcl_pkg::*;

  localparam int IDX_W = $clog2(CACHE_ENTRIES);

  cmd_t             cmd;
  logic [IDX_W-1:0] rd_addr;

  glcl_ctrl #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .action  (action),
    .busy    (busy),
    .cmd     (cmd),
    .rd_addr (rd_addr)
  );

  glcl_dp #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .rd_addr            (rd_addr),
    .action             (action),
    .code_point         (code_point),
    .done               (done),
    .hit                (hit),
    .slot               (slot),
    .evicted_valid      (evicted_valid),
    .evicted_code_point (evicted_code_point)
  );

endmodule

[rtl/core/glcl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module glcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/glcl_ctrl.sv]
// Sequencer for the tag store: accepts an item, walks the slots, commits.
// Depends on glcl_pkg.
module glcl_ctrl #(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [glcl_pkg::ACT_W-1:0]       action,
  output logic                             busy,
  output glcl_pkg::cmd_t                   cmd,
  output logic [$clog2(CACHE_ENTRIES)-1:0] rd_addr
);
  import glcl_pkg::*;

  localparam int IDX_W = $clog2(CACHE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

  state_t           state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic             scan_req;

  // lookups and inserts walk the slots, everything else commits at once
  assign scan_req = (action == ACT_LOOKUP) || (action == ACT_INSERT);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.init   = 1'b1;
          cnt_next   = '0;
          state_next = scan_req ? ST_SCAN : ST_COMMIT;
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (cnt == LAST_IDX) begin
          state_next = ST_LAST;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_LAST: begin
        // last read data is compared this cycle
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign busy    = (state != ST_IDLE);
  assign rd_addr = cnt;

endmodule

[rtl/core/glcl_dp.sv]
// Datapath: tag and stamp RAMs, valid bits, scan compare and update logic.
// Depends on glcl_pkg and glcl_ram.
module glcl_dp #(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  glcl_pkg::cmd_t                   cmd,
  input  logic [$clog2(CACHE_ENTRIES)-1:0] rd_addr,
  input  logic [glcl_pkg::ACT_W-1:0]       action,
  input  logic [glcl_pkg::TAG_W-1:0]       code_point,
  output logic                             done,
  output logic                             hit,
  output logic [glcl_pkg::SLOT_W-1:0]      slot,
  output logic                             evicted_valid,
  output logic [glcl_pkg::TAG_W-1:0]       evicted_code_point
);
  import glcl_pkg::*;

  localparam int IDX_W = $clog2(CACHE_ENTRIES);

  logic [ACT_W-1:0]         act;
  logic [TAG_W-1:0]         key;
  logic [CACHE_ENTRIES-1:0] valid;
  logic [STAMP_W-1:0]       access_counter;

  logic                     cmp_en;
  logic [IDX_W-1:0]         cmp_idx;
  logic [TAG_W-1:0]         tag_q;
  logic [STAMP_W-1:0]       stamp_q;

  logic                     found, inv_found;
  logic [IDX_W-1:0]         match_idx, inv_idx, min_idx;
  logic [STAMP_W-1:0]       min_stamp;
  logic [TAG_W-1:0]         min_tag;

  logic                     upd_hit, do_alloc, do_touch, evict;
  logic [IDX_W-1:0]         victim_idx, touch_idx;
  logic [STAMP_W-1:0]       counter_next;
  logic                     cmp_valid;

  // tag and stamp storage; no reset sweep, an entry is used only once written
  glcl_ram #(.WIDTH(TAG_W), .DEPTH(CACHE_ENTRIES)) u_tag_ram (
    .clk   (clk),
    .we    (cmd.commit && do_alloc),
    .waddr (touch_idx),
    .wdata (key),
    .raddr (rd_addr),
    .rdata (tag_q)
  );

  glcl_ram #(.WIDTH(STAMP_W), .DEPTH(CACHE_ENTRIES)) u_stamp_ram (
    .clk   (clk),
    .we    (cmd.commit && do_touch),
    .waddr (touch_idx),
    .wdata (counter_next),
    .raddr (rd_addr),
    .rdata (stamp_q)
  );

  // compare stage runs in the cycle after its read address is issued
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= cmd.issue;
    end
    cmp_idx <= rd_addr;
  end

  assign cmp_valid = valid[cmp_idx];

  // scan accumulators: first match, first free slot, oldest stamp
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      act       <= action;
      key       <= code_point;
      found     <= 1'b0;
      inv_found <= 1'b0;
    end else if (cmp_en) begin
      if (cmp_valid && (tag_q == key) && !found) begin
        found     <= 1'b1;
        match_idx <= cmp_idx;
      end
      if (!cmp_valid && !inv_found) begin
        inv_found <= 1'b1;
        inv_idx   <= cmp_idx;
      end
      if ((cmp_idx == '0) || (stamp_q < min_stamp)) begin
        min_stamp <= stamp_q;
        min_idx   <= cmp_idx;
        min_tag   <= tag_q;
      end
    end
  end

  // update decisions
  always_comb begin
    upd_hit      = found && ((act == ACT_LOOKUP) || (act == ACT_INSERT));
    do_alloc     = !found && (act == ACT_INSERT);
    do_touch     = upd_hit || do_alloc;
    victim_idx   = inv_found ? inv_idx : min_idx;
    touch_idx    = found ? match_idx : victim_idx;
    evict        = do_alloc && !inv_found;
    counter_next = access_counter + 1'b1;
  end

  // valid bits and access counter
  always_ff @(posedge clk) begin
    if (rst) begin
      valid          <= '0;
      access_counter <= '0;
    end else if (cmd.commit) begin
      if (act == ACT_CLEAR) begin
        valid <= '0;
      end else if (do_alloc) begin
        valid[touch_idx] <= 1'b1;
      end
      if (do_touch) begin
        access_counter <= counter_next;
      end
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.commit;
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit                <= upd_hit;
      slot               <= do_touch ? SLOT_W'(touch_idx) : '0;
      evicted_valid      <= evict;
      evicted_code_point <= evict ? min_tag : '0;
    end
  end

endmodule

[tb/glcl_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the glyph cache LRU tag store: predicts every accepted item
// and compares each done strobe with the oldest prediction. Needs glcl_pkg.
module glcl_checker #(
  parameter int ENTRIES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [glcl_pkg::ACT_W-1:0]  action,
  input  logic [glcl_pkg::TAG_W-1:0]  code_point,
  input  logic                        done,
  input  logic                        hit,
  input  logic [glcl_pkg::SLOT_W-1:0] slot,
  input  logic                        evicted_valid,
  input  logic [glcl_pkg::TAG_W-1:0]  evicted_code_point,
  output int                          fail_count,
  output int                          pending
);
  import glcl_pkg::*;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              ev_valid;
    logic [TAG_W-1:0]  ev_tag;
  } cache_result_t;

  // Shadow copy of the tag store
  logic               shadow_valid [ENTRIES];
  logic [TAG_W-1:0]   shadow_tag   [ENTRIES];
  logic [STAMP_W-1:0] shadow_stamp [ENTRIES];
  logic [STAMP_W-1:0] stamp_counter;

  cache_result_t expected_results[$];

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_tag[i]   = '0;
      shadow_stamp[i] = '0;
    end
    stamp_counter = '0;
    fail_count    = 0;
    pending       = 0;
  end

  // Bump the global counter and stamp one slot with it
  function automatic void refresh_stamp(int idx);
    stamp_counter     = stamp_counter + 1'b1;
    shadow_stamp[idx] = stamp_counter;
  endfunction

  // Apply one item to the shadow store and return the result it must give
  function automatic cache_result_t apply_cache_op(action_t act, logic [TAG_W-1:0] cp);
    cache_result_t r;
    int idx;
    r   = '0;
    idx = -1;
    if (act == ACT_LOOKUP || act == ACT_INSERT) begin
      for (int i = 0; i < ENTRIES; i++)
        if (idx < 0 && shadow_valid[i] && shadow_tag[i] == cp) idx = i;
      if (idx >= 0) begin
        refresh_stamp(idx);
        r.hit  = 1'b1;
        r.slot = SLOT_W'(idx);
      end else if (act == ACT_INSERT) begin
        // lowest free slot first, else oldest stamp, lowest index on a tie
        for (int i = 0; i < ENTRIES; i++)
          if (idx < 0 && !shadow_valid[i]) idx = i;
        if (idx < 0) begin
          idx = 0;
          for (int i = 1; i < ENTRIES; i++)
            if (shadow_stamp[i] < shadow_stamp[idx]) idx = i;
          r.ev_valid = 1'b1;
          r.ev_tag   = shadow_tag[idx];
        end
        shadow_tag[idx]   = cp;
        shadow_valid[idx] = 1'b1;
        refresh_stamp(idx);
        r.slot = SLOT_W'(idx);
      end
    end else if (act == ACT_CLEAR) begin
      // stamps and counter survive a clear
      for (int i = 0; i < ENTRIES; i++) shadow_valid[i] = 1'b0;
    end
    return r;
  endfunction

  function automatic int field_errors(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Compare results first so a result can never match an item taken at the same edge
  always @(posedge clk) begin
    cache_result_t want;
    int errs;
    if (!rst) begin
      errs = 0;
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding: hit=%0d slot=%0d ev=%0d tag=0x%0h",
                 hit, slot, evicted_valid, evicted_code_point);
          errs = 1;
        end else begin
          want = expected_results.pop_front();
          errs += field_errors("hit", want.hit, hit);
          errs += field_errors("slot", want.slot, slot);
          errs += field_errors("evicted_valid", want.ev_valid, evicted_valid);
          errs += field_errors("evicted_code_point", want.ev_tag, evicted_code_point);
        end
      end
      if (start && !busy)
        expected_results.push_back(apply_cache_op(action_t'(action), code_point));
      fail_count <= fail_count + errs;
      pending    <= expected_results.size();
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Top of the glyph cache LRU tag store bench: clock, reset, stimulus, verdict.
// Needs glcl_pkg, glyph_cache_lru_tag_store_unit and glcl_checker.
module tb_top;
  import glcl_pkg::*;

  localparam int ENTRIES        = 16;
  localparam int TOTAL_ITEMS    = 1350;
  localparam int CALM_TAIL      = 150;
  localparam int POOL_SIZE      = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 2 * (ENTRIES + 3);
  localparam logic [TAG_W-1:0] TAG_MAX     = '1;
  localparam logic [TAG_W-1:0] UNICODE_MAX = 21'd1114111;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  logic [ACT_W-1:0]  action;
  logic [TAG_W-1:0]  code_point;
  logic              done;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic              evicted_valid;
  logic [TAG_W-1:0]  evicted_code_point;
  int                fail_count;
  int                pending;

  int                quiet_cycles;
  int                items_issued;
  int                idle_pct;
  logic [TAG_W-1:0]  tag_pool[POOL_SIZE];

  always #2 clk = ~clk;

  glyph_cache_lru_tag_store_unit #(.CACHE_ENTRIES(ENTRIES)) dut (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .action             (action),
    .code_point         (code_point),
    .done               (done),
    .hit                (hit),
    .slot               (slot),
    .evicted_valid      (evicted_valid),
    .evicted_code_point (evicted_code_point)
  );

  glcl_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .action             (action),
    .code_point         (code_point),
    .done               (done),
    .hit                (hit),
    .slot               (slot),
    .evicted_valid      (evicted_valid),
    .evicted_code_point (evicted_code_point),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  // Watchdog: any accepted item or result restarts the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic logic [TAG_W-1:0] any_tag();
    if ($urandom_range(0, 1) == 0) return TAG_W'($urandom_range(0, UNICODE_MAX));
    return TAG_W'($urandom());
  endfunction

  // Mostly recycled tags so hits and evictions are common
  function automatic logic [TAG_W-1:0] pick_tag();
    if ($urandom_range(0, 9) == 0) return any_tag();
    return tag_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // Drive one item and hold it until the block takes it
  task automatic send_item(input action_t act, input logic [TAG_W-1:0] cp);
    int gap;
    if (items_issued < TOTAL_ITEMS - CALM_TAIL && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    action     <= act;
    code_point <= cp;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_issued++;
    // idle density changes every hundred items, zero included
    if (items_issued % 100 == 0) begin
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 20;
        default: idle_pct = 50;
      endcase
    end
  endtask

  // Hold the sender off until every outstanding result is back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [TAG_W-1:0] t;
    int r;
    rst          <= 1'b1;
    start        <= 1'b0;
    action       <= ACT_LOOKUP;
    code_point   <= '0;
    quiet_cycles = 0;
    items_issued = 0;
    idle_pct     = 30;
    for (int i = 0; i < POOL_SIZE; i++) tag_pool[i] = any_tag();
    tag_pool[0] = '0;
    tag_pool[1] = TAG_MAX;
    tag_pool[2] = UNICODE_MAX;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty miss, edge tags, hit, insert of a present key, unused action
    send_item(ACT_LOOKUP, '0);
    send_item(ACT_INSERT, '0);
    send_item(ACT_INSERT, TAG_MAX);
    send_item(ACT_INSERT, UNICODE_MAX);
    send_item(ACT_LOOKUP, TAG_MAX);
    send_item(ACT_INSERT, '0);
    send_item(ACT_NONE, TAG_MAX);
    // clear, then a miss on a formerly present tag
    send_item(ACT_CLEAR, 21'h0aaaaa);
    send_item(ACT_LOOKUP, '0);
    // fill every slot, then force an eviction of the oldest entry
    send_item(ACT_INSERT, 21'h155555);
    for (int k = 1; k < ENTRIES; k++) send_item(ACT_INSERT, TAG_W'(21'h100 + k * 21'h1357));
    send_item(ACT_INSERT, 21'h0aaaaa);
    send_item(ACT_LOOKUP, 21'h155555);
    drain_results();

    // Random: mostly lookup followed by insert of the same tag
    while (items_issued < TOTAL_ITEMS) begin
      if ($urandom_range(0, 19) == 0) tag_pool[$urandom_range(0, POOL_SIZE - 1)] = any_tag();
      if (items_issued > TOTAL_ITEMS / 2 && items_issued < TOTAL_ITEMS / 2 + 3)
        drain_results();
      t = pick_tag();
      r = $urandom_range(0, 99);
      if (r < 60) begin
        send_item(ACT_LOOKUP, t);
        send_item(ACT_INSERT, t);
      end else if (r < 78) begin
        send_item(ACT_INSERT, t);
      end else if (r < 95) begin
        send_item(ACT_LOOKUP, t);
      end else if (r < 97) begin
        send_item(ACT_CLEAR, any_tag());
      end else begin
        send_item(ACT_NONE, any_tag());
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[glyph_cache_lru_tag_store_unit.f]
rtl/core/glcl_pkg.sv
rtl/core/glcl_ram.sv
rtl/core/glcl_ctrl.sv
rtl/core/glcl_dp.sv
rtl/core/glyph_cache_lru_tag_store_unit.sv
tb/glcl_checker.sv
tb/tb_top.sv
